// ----- design/ivci_pkg.sv -----
// Shared types and constants for the current-voltage curve interpolator.
package ivci_pkg;

    // Field widths of one item
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 5;
    localparam int VOLT_W    = 16;
    localparam int CUR_W     = 16;
    localparam int POWER_W   = 32;

    // Stream bus widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    // Table entry: current above voltage
    localparam int ENTRY_W   = VOLT_W + CUR_W;

    // Restoring divider: quotient is known to fit the current width
    localparam int DIV_STEPS = CUR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Item kinds carried in s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE     = 2'd0,
        KIND_QUERY     = 2'd1,
        KIND_RECOMPUTE = 2'd2
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Control lines from the output decoder to the datapath
    typedef struct packed {
        logic issue_rd;
        logic out_load;
        logic mul_query;
    } ctrl_t;

endpackage

// ----- design/ivci_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ivci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/iv_curve_interpolator_unit.sv -----
// Top level: I-V curve table with interpolating lookup and peak power scan.
//
//  Channel  Dir  Handshake          Contents
//  s_       in   s_tvalid/s_tready  tuser: kind; tdata: index, voltage, current, query voltage
//  m_       out  m_tvalid/m_tready  tdata: current_out, max_power
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Write or unused kind: straight to the result state. Recompute: one RAM read
// per point, shared multiplier, compare. Query: a serial point search on the
// single RAM read port plus a 16-step restoring divide. Reset is synchronous,
// active low; table contents survive it undefined. A result waits in the output
// register; a stalled m_ side holds the sequencer in its result state only
// after the next item finishes.
module iv_curve_interpolator_unit #(
    parameter int POINTS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [4:0] point_index, [20:5] point_voltage, [36:21] point_current,
    // [52:37] query_voltage, [55:53] zero
    input  logic [ivci_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [ivci_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] current_out, [47:16] max_power
    output logic [ivci_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
    localparam int VW = ivci_pkg::VOLT_W;
    localparam int CW = ivci_pkg::CUR_W;
    localparam int PW = ivci_pkg::POWER_W;

    // Input field unpacking
    logic [ivci_pkg::INDEX_W-1:0] s_point_index;
    logic [VW-1:0]                s_point_voltage;
    logic signed [CW-1:0]         s_point_current;
    logic [VW-1:0]                s_query_voltage;
    logic                         s_xfer;

    assign s_point_index   = s_tdata[4:0];
    assign s_point_voltage = s_tdata[20:5];
    assign s_point_current = s_tdata[36:21];
    assign s_query_voltage = s_tdata[52:37];
    assign s_xfer          = s_tvalid && s_tready;

    // Registers
    ivci_pkg::state_t             state_reg, state_next;
    ivci_pkg::ctrl_t              ctrl;
    logic                         m_tvalid_reg;
    logic [ivci_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic signed [PW-1:0]         peak_reg;
    logic [IDX_W-1:0]             rd_addr_reg;
    logic                         issue_done_reg;
    logic                         dv_reg;
    logic [IDX_W-1:0]             data_idx_reg;
    logic                         pv_reg;
    logic                         plast_reg;
    logic signed [PW-1:0]         prod_reg;
    logic [VW-1:0]                vq_reg;
    logic [VW-1:0]                va_reg;
    logic signed [CW-1:0]         ia_reg;
    logic [VW-1:0]                dvq_reg;
    logic [VW-1:0]                den_reg;
    logic signed [CW:0]           di_reg;
    logic                         neg_reg;
    logic [VW-1:0]                rem_reg;
    logic [CW-1:0]                quo_reg;
    logic [ivci_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [CW-1:0]         cur_res_reg;

    // Table RAM
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ivci_pkg::ENTRY_W-1:0] ram_rdata;
    logic [VW-1:0]                rd_volt;
    logic signed [CW-1:0]         rd_cur;

    assign ram_we    = s_xfer && (s_tuser == ivci_pkg::KIND_WRITE)
                       && (32'(s_point_index) < POINTS);
    assign ram_waddr = IDX_W'(s_point_index);
    assign rd_volt   = ram_rdata[VW-1:0];
    assign rd_cur    = ram_rdata[ivci_pkg::ENTRY_W-1:VW];

    ivci_ram #(
        .WIDTH (ivci_pkg::ENTRY_W),
        .DEPTH (POINTS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_point_current, s_point_voltage}),
        .re    (ctrl.issue_rd),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Shared multiplier: interpolation numerator or point power
    logic signed [CW:0]      mul_a, mul_b;
    logic signed [2*CW+1:0]  mul_p;

    always_comb begin
        if (ctrl.mul_query) begin
            mul_a = signed'({1'b0, dvq_reg});
            mul_b = di_reg[CW] ? -di_reg : di_reg;
        end else begin
            mul_a = signed'({1'b0, rd_volt});
            mul_b = {rd_cur[CW-1], rd_cur};
        end
    end

    assign mul_p = mul_a * mul_b;

    // Search and scan status
    logic srch_hit, srch_last, scan_last;
    logic signed [PW-1:0] best_new;

    assign srch_hit  = dv_reg && (rd_volt > vq_reg);
    assign srch_last = dv_reg && (data_idx_reg == LAST_IDX);
    assign scan_last = pv_reg && plast_reg;
    assign best_new  = (prod_reg > peak_reg) ? prod_reg : peak_reg;

    // Restoring divide step
    logic [VW:0]   div_trial;
    logic          div_ge;
    logic [VW-1:0] div_rem;

    assign div_trial = {rem_reg, quo_reg[CW-1]};
    assign div_ge    = div_trial >= {1'b0, den_reg};
    assign div_rem   = div_ge ? VW'(div_trial - {1'b0, den_reg}) : div_trial[VW-1:0];

    // Final add: Ia plus signed quotient
    logic signed [CW:0] q_signed;
    logic signed [CW:0] sum_full;

    assign q_signed = neg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});
    assign sum_full = {ia_reg[CW-1], ia_reg} + q_signed;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ivci_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    case (s_tuser)
                        ivci_pkg::KIND_QUERY:     state_next = ivci_pkg::ST_SEARCH;
                        ivci_pkg::KIND_RECOMPUTE: state_next = ivci_pkg::ST_SCAN;
                        default:                  state_next = ivci_pkg::ST_RESULT;
                    endcase
                end
            end
            ivci_pkg::ST_SEARCH: begin
                if (srch_hit) begin
                    state_next = (data_idx_reg == '0) ? ivci_pkg::ST_RESULT
                                                      : ivci_pkg::ST_MUL;
                end else if (srch_last) begin
                    state_next = ivci_pkg::ST_RESULT;
                end
            end
            ivci_pkg::ST_MUL:  state_next = ivci_pkg::ST_DIV;
            ivci_pkg::ST_DIV: begin
                if (div_cnt_reg == ivci_pkg::DIV_CNT_W'(ivci_pkg::DIV_STEPS - 1)) begin
                    state_next = ivci_pkg::ST_SUM;
                end
            end
            ivci_pkg::ST_SUM:  state_next = ivci_pkg::ST_RESULT;
            ivci_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = ivci_pkg::ST_RESULT;
                end
            end
            ivci_pkg::ST_RESULT: begin
                if (ctrl.out_load) begin
                    state_next = ivci_pkg::ST_IDLE;
                end
            end
            default: state_next = ivci_pkg::ST_IDLE;
        endcase
    end

    // Output decode
    always_comb begin
        ctrl.issue_rd  = ((state_reg == ivci_pkg::ST_SEARCH) ||
                          (state_reg == ivci_pkg::ST_SCAN)) && !issue_done_reg;
        ctrl.out_load  = (state_reg == ivci_pkg::ST_RESULT) && (!m_tvalid_reg || m_tready);
        ctrl.mul_query = (state_reg == ivci_pkg::ST_MUL);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ivci_pkg::ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            peak_reg       <= '0;
            issue_done_reg <= 1'b1;
            dv_reg         <= 1'b0;
            pv_reg         <= 1'b0;
            rd_addr_reg    <= '0;
        end else begin
            state_reg <= state_next;
            dv_reg    <= ctrl.issue_rd;
            pv_reg    <= dv_reg && (state_reg == ivci_pkg::ST_SCAN);

            // Read address walk
            if (s_xfer) begin
                rd_addr_reg    <= '0;
                issue_done_reg <= 1'b0;
            end else if (ctrl.issue_rd) begin
                rd_addr_reg    <= rd_addr_reg + 1'b1;
                issue_done_reg <= (rd_addr_reg == LAST_IDX);
            end

            // Peak power: cleared at start of a scan, then running maximum
            if (s_xfer && (s_tuser == ivci_pkg::KIND_RECOMPUTE)) begin
                peak_reg <= '0;
            end else if ((state_reg == ivci_pkg::ST_SCAN) && pv_reg) begin
                peak_reg <= best_new;
            end

            // Output register
            if (ctrl.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        data_idx_reg <= rd_addr_reg;
        plast_reg    <= (data_idx_reg == LAST_IDX);
        if (dv_reg && (state_reg == ivci_pkg::ST_SCAN)) begin
            prod_reg <= mul_p[PW-1:0];
        end

        if (s_xfer) begin
            vq_reg      <= s_query_voltage;
            cur_res_reg <= '0;
        end

        case (state_reg)
            ivci_pkg::ST_SEARCH: begin
                if (dv_reg) begin
                    if (srch_hit) begin
                        if (data_idx_reg == '0) begin
                            cur_res_reg <= rd_cur;
                        end
                        dvq_reg <= vq_reg - va_reg;
                        den_reg <= rd_volt - va_reg;
                        di_reg  <= {rd_cur[CW-1], rd_cur} - {ia_reg[CW-1], ia_reg};
                    end else begin
                        va_reg <= rd_volt;
                        ia_reg <= rd_cur;
                        if (srch_last) begin
                            cur_res_reg <= rd_cur;
                        end
                    end
                end
            end
            ivci_pkg::ST_MUL: begin
                rem_reg     <= mul_p[2*CW-1:CW];
                quo_reg     <= mul_p[CW-1:0];
                neg_reg     <= di_reg[CW];
                div_cnt_reg <= '0;
            end
            ivci_pkg::ST_DIV: begin
                rem_reg     <= div_rem;
                quo_reg     <= {quo_reg[CW-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ivci_pkg::ST_SUM: begin
                cur_res_reg <= sum_full[CW-1:0];
            end
            default: begin
            end
        endcase

        if (ctrl.out_load) begin
            m_tdata_reg <= {peak_reg, cur_res_reg};
        end
    end

    assign s_tready = (state_reg == ivci_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/ivci_checker.sv -----
// Port-level checker for the I-V curve interpolator, bound to the top level.
module ivci_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ivci_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [ivci_pkg::KIND_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ivci_pkg::M_TDATA_W-1:0]  m_tdata
);

    // No result is pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // The block is busy in the cycle after it takes a transfer
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // A new result only appears while the block was busy with an item
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind iv_curve_interpolator_unit ivci_checker u_ivci_checker (.*);
